// ===== src/ssms_pkg.sv =====
// Package: shared constants, types and helpers for the sorted set search block.
`default_nettype none
package ssms_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_W       = 64;
    localparam int INDEX_W     = 8;
    localparam int COUNT_W     = 9;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    typedef struct packed {
        cmd_t  cmd;
        addr_t addr;
        key_t  key;
    } item_t;

    function automatic cnt_t sat_count(input logic [COUNT_W-1:0] count);
        if (int'(count) > TABLE_DEPTH) begin
            return CNT_W'(TABLE_DEPTH);
        end
        return CNT_W'(count);
    endfunction

endpackage
`default_nettype wire

// ===== src/ssms_if.sv =====
// Interfaces: request, response and configuration channels.
`default_nettype none
interface ssms_req_if;
    logic                             valid;
    logic                             ready;
    logic [0:0]                       command;
    logic [ssms_pkg::INDEX_W-1:0]     entry_index;
    logic signed [ssms_pkg::KEY_W-1:0] key;

    modport source (output valid, output command, output entry_index, output key,
                    input ready);
    modport sink   (input valid, input command, input entry_index, input key,
                    output ready);
endinterface

interface ssms_rsp_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, output found, input ready);
    modport sink   (input valid, input found, output ready);
endinterface

interface ssms_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ssms_pkg::COUNT_W-1:0] entry_count;

    modport source (output valid, output entry_count, input ready);
    modport sink   (input valid, input entry_count, output ready);
endinterface
`default_nettype wire

// ===== src/ssms_front.sv =====
// Front end: accepts request items, drops out-of-range writes, stages items for the queue.
`default_nettype none
module ssms_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    ssms_req_if.sink           req,
    output ssms_pkg::item_t    push_item,
    output logic               push_valid,
    input  wire logic          push_ready
);
    import ssms_pkg::*;

    logic  stage_valid_reg;
    logic  stage_valid_next;
    item_t stage_item_reg;
    logic  accept;
    logic  keep;

    assign req.ready = !stage_valid_reg || push_ready;
    assign accept    = req.valid && req.ready;
    // writes beyond the table are discarded here
    assign keep      = (cmd_t'(req.command) == CMD_QUERY) ||
                       (int'(req.entry_index) < TABLE_DEPTH);

    always_comb
    begin
        stage_valid_next = stage_valid_reg && !push_ready;
        if (accept && keep)
        begin
            stage_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            stage_item_reg.cmd  <= cmd_t'(req.command);
            stage_item_reg.addr <= ADDR_W'(req.entry_index);
            stage_item_reg.key  <= req.key;
        end
    end

    assign push_valid = stage_valid_reg;
    assign push_item  = stage_item_reg;

endmodule
`default_nettype wire

// ===== src/ssms_queue.sv =====
// Short FIFO between front end and search engine.
`default_nettype none
module ssms_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ssms_pkg::item_t  push_item,
    input  wire logic             push_valid,
    output logic                  push_ready,
    output ssms_pkg::item_t       pop_item,
    output logic                  pop_valid,
    input  wire logic             pop_ready
);
    import ssms_pkg::*;

    item_t               slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   fill_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   fill_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (int'(fill_reg) < QUEUE_DEPTH);
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ===== src/ssms_back.sv =====
// Search engine: entry table, count register, binary search and result register.
`default_nettype none
module ssms_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ssms_pkg::item_t  pop_item,
    input  wire logic             pop_valid,
    output logic                  pop_ready,
    ssms_cfg_if.sink              cfg,
    ssms_rsp_if.source            rsp
);
    import ssms_pkg::*;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    key_t                 table_mem [TABLE_DEPTH];
    key_t                 rd_data_reg;

    state_t               state_reg;
    state_t               state_next;
    logic [COUNT_W-1:0]   count_reg;
    cnt_t                 lo_reg;
    cnt_t                 lo_next;
    cnt_t                 hi_reg;
    cnt_t                 hi_next;
    cnt_t                 mid_reg;
    cnt_t                 mid_next;
    key_t                 key_reg;
    key_t                 key_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 found_reg;
    logic                 found_next;

    cnt_t                 limit;
    cnt_t                 lo_step;
    cnt_t                 hi_step;
    logic [CNT_W:0]       mid_sum;
    logic                 out_free;
    logic                 rd_en;
    logic                 wr_en;

    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.found = found_reg;

    assign limit    = sat_count(count_reg);
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        found_next     = found_reg;
        pop_ready      = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        lo_step        = lo_reg;
        hi_step        = hi_reg;
        mid_sum        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    if (pop_item.cmd == CMD_WRITE)
                    begin
                        wr_en     = 1'b1;
                        pop_ready = 1'b1;
                    end
                    else if (limit == '0)
                    begin
                        if (out_free)
                        begin
                            pop_ready      = 1'b1;
                            out_valid_next = 1'b1;
                            found_next     = 1'b0;
                        end
                    end
                    else
                    begin
                        pop_ready  = 1'b1;
                        lo_next    = '0;
                        hi_next    = limit;
                        mid_next   = limit >> 1;
                        key_next   = pop_item.key;
                        rd_en      = 1'b1;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (key_reg == rd_data_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        found_next     = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    if (key_reg < rd_data_reg)
                    begin
                        hi_step = mid_reg;
                    end
                    else
                    begin
                        lo_step = mid_reg + 1'b1;
                    end
                    if (lo_step >= hi_step)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            found_next     = 1'b0;
                            state_next     = ST_IDLE;
                        end
                    end
                    else
                    begin
                        mid_sum  = {1'b0, lo_step} + {1'b0, hi_step};
                        lo_next  = lo_step;
                        hi_next  = hi_step;
                        mid_next = mid_sum[CNT_W:1];
                        rd_en    = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            if (cfg.valid && cfg.ready)
            begin
                count_reg <= cfg.entry_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        found_reg <= found_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[pop_item.addr] <= pop_item.key;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[mid_next[ADDR_W-1:0]];
        end
    end

endmodule
`default_nettype wire

// ===== src/sorted_set_membership_search.sv =====
// Top level: membership search over a sorted table of signed 64-bit keys.
//
// Channels (valid/ready, an item moves when both are high at a clock edge):
//   req : command 0 writes key into entry entry_index, command 1 queries key.
//   rsp : one item per query, found = 1 when the search meets an equal entry.
//   cfg : writes entry_count, the number of leading entries searched
//         (values above the table depth act as the full table).
// Load the table in ascending order before querying; write cfg only when idle.
// Flow: a request item is registered in the front stage and passes a
// two-entry queue. A write is then stored by the search engine. A query
// is started by issuing a first table read and then runs halving steps,
// each step being one table read plus a 64-bit compare: at most
// log2(depth)+1 steps, fewer on an early match or a short count. Queries are
// handled one at a time; writes keep one per cycle unless a query is searching.
// Reset clears the count to zero, all control state and the result valid flag;
// table contents stay undefined until written.
// When rsp stalls, the finished result holds and the engine waits at the end
// of its next query; the front stage and queue keep taking items until full.
`default_nettype none
module sorted_set_membership_search (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ssms_req_if.sink    req,
    ssms_rsp_if.source  rsp,
    ssms_cfg_if.sink    cfg
);
    import ssms_pkg::*;

    item_t push_item;
    logic  push_valid;
    logic  push_ready;
    item_t pop_item;
    logic  pop_valid;
    logic  pop_ready;

    ssms_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    ssms_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    ssms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_item  (pop_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .cfg       (cfg),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

// ===== sim/sorted_set_membership_search_test.sv =====
// Testbench: random and directed table loads and membership queries against a search predictor.
module sorted_set_membership_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssms_pkg::*;

    localparam int     ITEM_TARGET  = 1700;
    localparam int     DRAIN_CYCLES = 24;
    localparam int     HOLD_CYCLES  = 200;
    localparam int     MAX_REPORTS  = 10;
    localparam longint KEY_MIN      = 64'sh8000_0000_0000_0000;
    localparam longint KEY_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;

    class found_scoreboard;
        longint      entries[TABLE_DEPTH];
        int unsigned search_limit;
        bit          pending_found[$];
        int          mismatches;
        int          checked;
        int          hits;
        int          writes;
        int          queries;

        function new();
            search_limit = 0;
            mismatches = 0;
            checked = 0;
            hits = 0;
            writes = 0;
            queries = 0;
        endfunction

        function void set_count(logic [COUNT_W-1:0] value);
            search_limit = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
        endfunction

        function bit search_table(longint k);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = search_limit;
            while (lo < hi)
            begin
                mid = (lo + hi) >> 1;
                if (k < entries[mid])
                    hi = mid;
                else if (k > entries[mid])
                    lo = mid + 1;
                else
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_request(cmd_t c, logic [INDEX_W-1:0] idx, longint k);
            if (c == CMD_WRITE)
            begin
                entries[idx] = k;
                writes++;
            end
            else
            begin
                pending_found.push_back(search_table(k));
                queries++;
            end
        endfunction

        function void report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch at %0t: %s", $realtime, msg);
        endfunction

        function void check_result(logic found);
            bit want;
            if (pending_found.size() == 0)
            begin
                report_mismatch($sformatf("result found=%0b with no query waiting", found));
                return;
            end
            want = pending_found.pop_front();
            checked++;
            if (want)
                hits++;
            if (found !== want)
                report_mismatch($sformatf("result %0d: found expected %0b, got %0b",
                                          checked, want, found));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ssms_req_if req();
    ssms_rsp_if rsp();
    ssms_cfg_if cfg();

    sorted_set_membership_search dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    found_scoreboard board;
    int sent_items;
    int count_settings;
    bit hold_pending;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // sender runs gap-free for a stretch of items
    task automatic offer_request(cmd_t c, logic [INDEX_W-1:0] idx, longint k);
        while (!(sent_items >= 400 && sent_items < 700) && $urandom_range(0, 99) < 33)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.command     <= c;
        req.entry_index <= idx;
        req.key         <= k;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        board.note_request(c, idx, k);
        sent_items++;
    endtask

    task automatic set_entry_count(logic [COUNT_W-1:0] value);
        req.valid <= 1'b0;
        while (board.pending_found.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg.valid       <= 1'b1;
        cfg.entry_count <= value;
        @(posedge clk);
        while (cfg.ready !== 1'b1)
            @(posedge clk);
        cfg.valid <= 1'b0;
        board.set_count(value);
        count_settings++;
    endtask

    function automatic longint extreme_key();
        case ($urandom_range(0, 5))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return 64'sd0;
            3: return -64'sd1;
            4: return KEY_MIN + 1;
            default: return KEY_MAX - 1;
        endcase
    endfunction

    function automatic longint phase_key(int mode);
        case (mode)
            0: return longint'({$urandom(), $urandom()});
            1: return longint'($urandom_range(0, 100)) - 50;
            2: return ($urandom_range(0, 99) < 25) ? extreme_key()
                                                   : longint'({$urandom(), $urandom()});
            default: return longint'(int'($urandom()));
        endcase
    endfunction

    // load entries 0..n-1 (sorted unless scrambled), then a mix of queries and stray writes
    task automatic run_phase(logic [COUNT_W-1:0] count_value, int n_queries, int mode,
                             bit scramble, bit pressure);
        longint loaded[$];
        int     n;
        int     pick;
        int     slot;
        longint k;
        n = (count_value > TABLE_DEPTH) ? TABLE_DEPTH : count_value;
        set_entry_count(count_value);
        for (int i = 0; i < n; i++)
            loaded.push_back(phase_key(mode));
        if (!scramble)
            loaded.sort();
        for (int i = 0; i < n; i++)
            offer_request(CMD_WRITE, INDEX_W'(i), loaded[i]);
        if (pressure)
            hold_pending = 1'b1;
        for (int q = 0; q < n_queries; q++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                slot = $urandom_range(0, TABLE_DEPTH - 1);
                k = phase_key(mode);
                if (slot < n)
                    loaded[slot] = k;
                offer_request(CMD_WRITE, INDEX_W'(slot), k);
                continue;
            end
            if (n > 0 && pick < 45)
                k = loaded[$urandom_range(0, n - 1)];
            else if (n > 0 && pick < 60)
                k = loaded[$urandom_range(0, n - 1)] + (($urandom_range(0, 1) == 1) ? 1 : -1);
            else if (pick < 70)
                k = extreme_key();
            else
                k = phase_key(mode);
            offer_request(CMD_QUERY, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)), k);
        end
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                board.check_result(rsp.found);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if (hold_pending)
            begin
                hold_pending = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                rsp.ready <= 1'b0;
            end
            else if (board.checked >= 150 && board.checked < 350)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 99) >= 33);
        end
    end

    initial
    begin
        int r;
        logic [COUNT_W-1:0] count_value;
        board = new();
        sent_items = 0;
        count_settings = 0;
        hold_pending = 1'b0;
        rst_n <= 1'b0;
        req.valid <= 1'b0;
        req.command <= CMD_WRITE;
        req.entry_index <= '0;
        req.key <= '0;
        cfg.valid <= 1'b0;
        cfg.entry_count <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // count is zero out of reset: nothing can be found
        offer_request(CMD_QUERY, '0, KEY_MIN);
        offer_request(CMD_QUERY, 8'hFF, 64'sd0);
        offer_request(CMD_QUERY, 8'hAA, KEY_MAX);
        offer_request(CMD_WRITE, INDEX_W'(0), KEY_MIN);
        offer_request(CMD_WRITE, INDEX_W'(1), -64'sd1);
        offer_request(CMD_WRITE, INDEX_W'(2), 64'sd0);
        offer_request(CMD_WRITE, INDEX_W'(3), 64'sd1);
        offer_request(CMD_WRITE, INDEX_W'(4), KEY_MAX);
        offer_request(CMD_WRITE, 8'hFF, 64'sh5555_5555_5555_5555);
        set_entry_count(COUNT_W'(5));
        offer_request(CMD_QUERY, '0, KEY_MIN);
        offer_request(CMD_QUERY, '0, KEY_MAX);
        offer_request(CMD_QUERY, '0, -64'sd1);
        offer_request(CMD_QUERY, '0, 64'sd0);
        offer_request(CMD_QUERY, '0, 64'sd1);
        offer_request(CMD_QUERY, '0, KEY_MIN + 1);
        offer_request(CMD_QUERY, '0, KEY_MAX - 1);
        offer_request(CMD_QUERY, '0, -64'sd2);
        offer_request(CMD_QUERY, '0, 64'sd2);
        set_entry_count(COUNT_W'(1));
        offer_request(CMD_QUERY, '0, KEY_MIN);
        offer_request(CMD_QUERY, '0, -64'sd1);
        set_entry_count(COUNT_W'(2));
        offer_request(CMD_QUERY, '0, -64'sd1);
        offer_request(CMD_QUERY, '0, KEY_MAX);

        // full table with a long result stall while queries keep coming
        run_phase(COUNT_W'(TABLE_DEPTH), 60, 0, 1'b0, 1'b1);

        while (sent_items < ITEM_TARGET - 330)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                count_value = '0;
            else if (r < 60)
                count_value = COUNT_W'($urandom_range(1, 8));
            else if (r < 85)
                count_value = COUNT_W'($urandom_range(9, 40));
            else if (r < 95)
                count_value = COUNT_W'($urandom_range(41, 100));
            else
                count_value = COUNT_W'($urandom_range(101, TABLE_DEPTH - 1));
            run_phase(count_value, $urandom_range(10, 40), $urandom_range(0, 3),
                      $urandom_range(0, 99) < 12, 1'b0);
        end

        // count above the table depth saturates
        run_phase(9'h1FF, 60, 2, 1'b0, 1'b0);

        req.valid <= 1'b0;
        while (board.pending_found.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d table writes and %0d queries (%0d hits) over %0d count settings",
                 board.writes, board.queries, board.hits, count_settings);
        $display("checked %0d results, %0d mismatches", board.checked, board.mismatches);
        if (board.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
